>>> rtl/core/srtm_pkg.sv
package srtm_pkg;

  localparam int RING_DEPTH    = 128;
  localparam int SCAN_CHANNELS = 8;
  localparam int WINDOW        = 10;
  localparam int TRIM_SHIFT    = 3;

  localparam int SMP_W = 12;
  localparam int CH_W  = 4;
  localparam int AVG_W = 16;
  localparam int AW    = $clog2(RING_DEPTH);
  localparam int RW    = AW + 1;
  localparam int MOD_W = (SCAN_CHANNELS > 1) ? $clog2(SCAN_CHANNELS) : 1;
  localparam int CNT_W = $clog2(WINDOW);
  localparam int SUM_W = $clog2(WINDOW * (1 << SMP_W));

  typedef logic [SMP_W-1:0] smp_t;
  typedef logic [CH_W-1:0]  ch_t;
  typedef logic [AVG_W-1:0] avg_t;
  typedef logic [AW-1:0]    addr_t;
  typedef logic [RW-1:0]    rw_t;
  typedef logic [MOD_W-1:0] mod_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SUM_W-1:0] sum_t;

  localparam rw_t D_RW     = rw_t'(RING_DEPTH);
  localparam rw_t S_RW     = rw_t'(SCAN_CHANNELS);
  localparam rw_t BACK_RW  = rw_t'(SCAN_CHANNELS % RING_DEPTH);
  localparam rw_t DMODS_RW = rw_t'(RING_DEPTH % SCAN_CHANNELS);
  localparam logic [CH_W:0] CH_LIM = (CH_W + 1)'(SCAN_CHANNELS);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // microprogram
  typedef logic [1:0] step_t;
  localparam step_t ST_IDLE  = 2'd0;
  localparam step_t ST_LOOP  = 2'd1;
  localparam step_t ST_DRAIN = 2'd2;
  localparam step_t ST_FIN   = 2'd3;

  typedef enum logic [1:0] {
    COND_NEXT     = 2'd0,
    COND_DISPATCH = 2'd1,
    COND_LOOP     = 2'd2,
    COND_HOLD     = 2'd3
  } cond_t;

  typedef struct packed {
    logic  accept;
    logic  rd_en;
    logic  acc;
    logic  fin;
    cond_t cond;
    step_t target;
  } uword_t;

  // sequencer -> datapath
  typedef struct packed {
    logic take;
    logic rd_en;
    logic acc;
    logic load_out;
  } ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic in_range;
    logic last;
    logic out_hold;
  } sts_t;

endpackage

>>> rtl/core/scan_ring_trimmed_mean.sv
// Trimmed mean over a multi-channel scan ring.
// Input channel (in_valid / in_stall): in_kind 0 stores in_sample_value at the
// next ring slot; in_kind 1 queries in_channel and produces one result.
// Result channel (out_valid / out_stall): out_average is the sum of the
// newest WINDOW samples of the channel, minus min and max, shifted right by 3;
// a channel outside the scan answers 0.
// Steps: a sample request is taken in the idle step and gives no result.
// A query is taken in the idle step; WINDOW ring reads then issue one per
// cycle through the single read port, a drain step absorbs the last read and
// the final step loads the output register. An out-of-scan query skips there.
// in_stall is low only while the sequencer sits in its idle step.
// Reset (synchronous, rst_n low) empties the ring: per-entry valid bits are
// cleared at once, so unwritten slots read as zero; no clearing pass.
// A result waits in the output register while out_stall is high; the next
// request is still taken, and a following query holds in its final step until
// the waiting result is taken.
module scan_ring_trimmed_mean (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [11:0]           in_sample_value,
  input  logic [3:0]            in_channel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_average
);

  srtm_pkg::ctl_t ctl;
  srtm_pkg::sts_t sts;

  srtm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .sts      (sts),
    .ctl      (ctl),
    .in_stall (in_stall)
  );

  srtm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_kind         (in_kind),
    .in_sample_value (in_sample_value),
    .in_channel      (in_channel),
    .out_stall       (out_stall),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_average     (out_average)
  );

endmodule

>>> rtl/core/srtm_ram.sv
module srtm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 128
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/srtm_seq.sv
module srtm_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  input  srtm_pkg::sts_t    sts,
  output srtm_pkg::ctl_t    ctl,
  output logic              in_stall
);

  function automatic srtm_pkg::uword_t urom(input srtm_pkg::step_t s);
    srtm_pkg::uword_t w;
    w = '0;
    case (s)
      srtm_pkg::ST_IDLE: begin
        w.accept = 1'b1;
        w.cond   = srtm_pkg::COND_DISPATCH;
        w.target = srtm_pkg::ST_LOOP;
      end
      srtm_pkg::ST_LOOP: begin
        w.rd_en  = 1'b1;
        w.acc    = 1'b1;
        w.cond   = srtm_pkg::COND_LOOP;
        w.target = srtm_pkg::ST_LOOP;
      end
      srtm_pkg::ST_DRAIN: begin
        w.acc    = 1'b1;
        w.cond   = srtm_pkg::COND_NEXT;
        w.target = srtm_pkg::ST_FIN;
      end
      srtm_pkg::ST_FIN: begin
        w.fin    = 1'b1;
        w.cond   = srtm_pkg::COND_HOLD;
        w.target = srtm_pkg::ST_IDLE;
      end
      default: begin
        w.cond   = srtm_pkg::COND_HOLD;
        w.target = srtm_pkg::ST_IDLE;
      end
    endcase
    return w;
  endfunction

  srtm_pkg::step_t  step_r, step_nxt;
  srtm_pkg::uword_t uw;

  assign uw       = urom(step_r);
  assign in_stall = !uw.accept;

  always_comb begin
    ctl.take     = uw.accept && in_valid;
    ctl.rd_en    = uw.rd_en;
    ctl.acc      = uw.acc;
    ctl.load_out = uw.fin && !sts.out_hold;
  end

  always_comb begin
    step_nxt = step_r;
    case (uw.cond)
      srtm_pkg::COND_NEXT: begin
        step_nxt = step_r + srtm_pkg::step_t'(1);
      end
      srtm_pkg::COND_DISPATCH: begin
        if (in_valid && in_kind == srtm_pkg::KIND_QUERY) begin
          step_nxt = sts.in_range ? uw.target : srtm_pkg::ST_FIN;
        end
      end
      srtm_pkg::COND_LOOP: begin
        step_nxt = sts.last ? step_r + srtm_pkg::step_t'(1) : uw.target;
      end
      srtm_pkg::COND_HOLD: begin
        step_nxt = sts.out_hold ? step_r : uw.target;
      end
      default: begin
        step_nxt = srtm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= srtm_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> rtl/core/srtm_dp.sv
module srtm_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  srtm_pkg::ctl_t    ctl,
  input  logic              in_kind,
  input  srtm_pkg::smp_t    in_sample_value,
  input  srtm_pkg::ch_t     in_channel,
  input  logic              out_stall,
  output srtm_pkg::sts_t    sts,
  output logic              out_valid,
  output srtm_pkg::avg_t    out_average
);

  srtm_pkg::addr_t wp_r, wp_nxt;
  srtm_pkg::mod_t  wpm_r, wpm_nxt;
  srtm_pkg::addr_t pos_r;
  srtm_pkg::cnt_t  cnt_r;
  srtm_pkg::sum_t  sum_r;
  srtm_pkg::smp_t  lo_r, hi_r;
  logic            first_r;
  logic            zero_r;
  logic            rd_vld_r;
  logic            ent_ok_r;
  logic            vld_r [srtm_pkg::RING_DEPTH];
  logic            out_valid_r;
  srtm_pkg::avg_t  out_average_r;

  logic            wr_en;
  srtm_pkg::smp_t  rdata;
  srtm_pkg::smp_t  v;
  srtm_pkg::rw_t   wp_e, p, pm, pms, slot, pos_e, bk, ch_e;
  srtm_pkg::addr_t slot_a, back_a;
  srtm_pkg::sum_t  trim;
  logic            query_take;

  assign wr_en      = ctl.take && in_kind == srtm_pkg::KIND_SAMPLE;
  assign query_take = ctl.take && in_kind == srtm_pkg::KIND_QUERY;

  // newest complete scan group, plus channel offset
  always_comb begin
    wp_e = {1'b0, wp_r};
    ch_e = srtm_pkg::rw_t'(in_channel);
    pms  = srtm_pkg::rw_t'(wpm_r) + srtm_pkg::DMODS_RW;
    if (wp_e >= srtm_pkg::S_RW) begin
      p  = wp_e - srtm_pkg::S_RW;
      pm = srtm_pkg::rw_t'(wpm_r);
    end else begin
      p  = wp_e + srtm_pkg::D_RW - srtm_pkg::S_RW;
      pm = (pms >= srtm_pkg::S_RW) ? pms - srtm_pkg::S_RW : pms;
    end
    slot = p - pm + ch_e;
    if (slot >= srtm_pkg::D_RW) begin
      slot = slot - srtm_pkg::D_RW;
    end
    slot_a = slot[srtm_pkg::AW-1:0];
  end

  always_comb begin
    pos_e  = {1'b0, pos_r};
    bk     = (pos_e >= srtm_pkg::BACK_RW) ? pos_e - srtm_pkg::BACK_RW
                                          : pos_e + srtm_pkg::D_RW - srtm_pkg::BACK_RW;
    back_a = bk[srtm_pkg::AW-1:0];
  end

  always_comb begin
    if (wp_r == srtm_pkg::addr_t'(srtm_pkg::RING_DEPTH - 1)) begin
      wp_nxt  = '0;
      wpm_nxt = '0;
    end else begin
      wp_nxt  = wp_r + srtm_pkg::addr_t'(1);
      wpm_nxt = (wpm_r == srtm_pkg::mod_t'(srtm_pkg::SCAN_CHANNELS - 1)) ? '0
                : wpm_r + srtm_pkg::mod_t'(1);
    end
  end

  srtm_ram #(
    .WIDTH (srtm_pkg::SMP_W),
    .DEPTH (srtm_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wp_r),
    .wdata (in_sample_value),
    .re    (ctl.rd_en),
    .raddr (pos_r),
    .rdata (rdata)
  );

  assign v    = ent_ok_r ? rdata : '0;
  assign trim = sum_r - srtm_pkg::sum_t'(lo_r) - srtm_pkg::sum_t'(hi_r);

  always_comb begin
    sts.in_range = {1'b0, in_channel} < srtm_pkg::CH_LIM;
    sts.last     = cnt_r == srtm_pkg::cnt_t'(srtm_pkg::WINDOW - 1);
    sts.out_hold = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      wpm_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < srtm_pkg::RING_DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      rd_vld_r <= ctl.rd_en;
      if (wr_en) begin
        wp_r        <= wp_nxt;
        wpm_r       <= wpm_nxt;
        vld_r[wp_r] <= 1'b1;
      end
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_take) begin
      pos_r   <= slot_a;
      cnt_r   <= '0;
      sum_r   <= '0;
      first_r <= 1'b1;
      zero_r  <= !sts.in_range;
    end
    if (ctl.rd_en) begin
      ent_ok_r <= vld_r[pos_r];
      pos_r    <= back_a;
      cnt_r    <= cnt_r + srtm_pkg::cnt_t'(1);
    end
    if (ctl.acc && rd_vld_r) begin
      sum_r   <= sum_r + srtm_pkg::sum_t'(v);
      first_r <= 1'b0;
      if (first_r || v < lo_r) begin
        lo_r <= v;
      end
      if (first_r || v > hi_r) begin
        hi_r <= v;
      end
    end
    if (ctl.load_out) begin
      out_average_r <= zero_r ? '0
                       : srtm_pkg::avg_t'(trim >> srtm_pkg::TRIM_SHIFT);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> !(out_valid_r && out_stall))
    else $error("result loaded over a held result");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_en |-> !ctl.take)
    else $error("request taken during read sweep");

  a_acc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.acc && rd_vld_r) |-> $past(ctl.rd_en))
    else $error("accumulate without a preceding read");
`endif

endmodule

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srtm_pkg::*;

  localparam int RAND_ITEMS  = 1280;
  localparam int DRAIN_CYC   = 4 * (WINDOW + 3);
  localparam int STUCK_LIMIT = 400;
  localparam int DIR_N       = 20;

  typedef struct packed {
    logic kind;
    smp_t val;
    ch_t  ch;
    logic typed;
    avg_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_kind;
  logic [11:0] in_sample_value;
  logic [3:0] in_channel;
  logic out_valid;
  logic out_stall;
  logic [15:0] out_average;

  scan_ring_trimmed_mean DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_sample_value(in_sample_value),
    .in_channel(in_channel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_average(out_average)
  );

  smp_t ring_img [RING_DEPTH];
  int unsigned wr_slot;
  avg_t avg_q [$];
  avg_t head_avg;
  int mismatches;
  int stuck_cycles;
  bit in_quiet;
  bit out_quiet;
  dir_row_t dir_rows [DIR_N];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned scan_back(int unsigned slot);
    return (slot + RING_DEPTH - (SCAN_CHANNELS % RING_DEPTH)) % RING_DEPTH;
  endfunction

  // newest complete scan group, then WINDOW entries back, min and max dropped
  function automatic avg_t trimmed_avg(ch_t ch);
    int unsigned slot;
    int unsigned total;
    int unsigned lo;
    int unsigned hi;
    int unsigned v;
    if (ch >= SCAN_CHANNELS)
      return '0;
    slot = scan_back(wr_slot % RING_DEPTH);
    slot = slot - (slot % SCAN_CHANNELS);
    slot = (slot + ch) % RING_DEPTH;
    lo = ring_img[slot];
    hi = lo;
    total = 0;
    for (int i = 0; i < WINDOW; i++) begin
      v = ring_img[slot];
      total += v;
      if (v < lo)
        lo = v;
      if (v > hi)
        hi = v;
      slot = scan_back(slot);
    end
    return avg_t'((total - lo - hi) >> TRIM_SHIFT);
  endfunction

  task automatic issue(logic kind, smp_t val, ch_t ch, logic typed, avg_t want);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_sample_value <= val;
    in_channel      <= ch;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_SAMPLE) begin
      ring_img[wr_slot % RING_DEPTH] = val;
      wr_slot = (wr_slot + 1) % RING_DEPTH;
    end else begin
      avg_q.push_back(typed ? want : trimmed_avg(ch));
    end
  endtask

  initial begin
    int sent;
    int burst_len;
    int mode;
    int q_pct;
    smp_t val;
    ch_t ch;
    dir_rows = '{
      '{KIND_QUERY,  12'd0,    4'd0,  1'b1, 16'd0},
      '{KIND_QUERY,  12'd4095, 4'd7,  1'b1, 16'd0},
      '{KIND_QUERY,  12'd0,    4'd8,  1'b1, 16'd0},
      '{KIND_QUERY,  12'd4095, 4'd15, 1'b1, 16'd0},
      '{KIND_SAMPLE, 12'd4095, 4'd15, 1'b0, 16'd0},
      '{KIND_SAMPLE, 12'd4095, 4'd0,  1'b0, 16'd0},
      '{KIND_SAMPLE, 12'd4095, 4'd15, 1'b0, 16'd0},
      '{KIND_SAMPLE, 12'd4095, 4'd0,  1'b0, 16'd0},
      '{KIND_SAMPLE, 12'd4095, 4'd15, 1'b0, 16'd0},
      '{KIND_SAMPLE, 12'd4095, 4'd0,  1'b0, 16'd0},
      '{KIND_SAMPLE, 12'd4095, 4'd15, 1'b0, 16'd0},
      '{KIND_SAMPLE, 12'd4095, 4'd0,  1'b0, 16'd0},
      '{KIND_QUERY,  12'd0,    4'd0,  1'b0, 16'd0},
      '{KIND_QUERY,  12'd4095, 4'd7,  1'b0, 16'd0},
      '{KIND_SAMPLE, 12'd0,    4'd15, 1'b0, 16'd0},
      '{KIND_SAMPLE, 12'hAAA,  4'd10, 1'b0, 16'd0},
      '{KIND_SAMPLE, 12'h555,  4'd5,  1'b0, 16'd0},
      '{KIND_QUERY,  12'h555,  4'd1,  1'b0, 16'd0},
      '{KIND_QUERY,  12'd0,    4'd15, 1'b1, 16'd0},
      '{KIND_QUERY,  12'hAAA,  4'd8,  1'b1, 16'd0}
    };
    for (int i = 0; i < RING_DEPTH; i++)
      ring_img[i] = '0;
    wr_slot    = 0;
    mismatches = 0;
    in_quiet   = 1'b0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_kind         <= KIND_SAMPLE;
    in_sample_value <= '0;
    in_channel      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++)
      issue(dir_rows[i].kind, dir_rows[i].val, dir_rows[i].ch, dir_rows[i].typed,
            dir_rows[i].want);

    // bursts: value pattern, query density and idling vary per burst
    sent = 0;
    while (sent < RAND_ITEMS) begin
      burst_len = $urandom_range(1, 100);
      mode      = $urandom_range(0, 4);
      q_pct     = $urandom_range(3, 50);
      in_quiet  = ($urandom_range(0, 4) == 0);
      repeat (burst_len) begin
        if ($urandom_range(1, 100) <= q_pct) begin
          ch = ($urandom_range(0, 3) == 0) ? ch_t'($urandom_range(SCAN_CHANNELS, 15))
                                           : ch_t'($urandom_range(0, SCAN_CHANNELS - 1));
          issue(KIND_QUERY, smp_t'($urandom_range(0, 4095)), ch, 1'b0, '0);
        end else begin
          case (mode)
            0: val = smp_t'($urandom_range(0, 4095));
            1: val = 12'd4095;
            2: val = ($urandom_range(0, 1) == 1) ? 12'd4095 : 12'd0;
            3: val = smp_t'($urandom_range(0, 3));
            default: val = smp_t'(4095 - $urandom_range(0, 15));
          endcase
          issue(KIND_SAMPLE, val, ch_t'($urandom_range(0, 15)), 1'b0, '0);
        end
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (avg_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int hold;
    int taken;
    taken     = 0;
    out_quiet = 1'b0;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 16 == 0)
        out_quiet = ($urandom_range(0, 3) == 0);
      hold = out_quiet ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1));
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (avg_q.size() == 0) begin
        $error("unexpected result: out_average expected none actual %0d", out_average);
        mismatches++;
      end else begin
        head_avg = avg_q.pop_front();
        if (out_average !== head_avg) begin
          $error("out_average expected %0d actual %0d", head_avg, out_average);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      stuck_cycles <= 0;
    else if ((in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
